[rtl/stmtc_pkg.sv]
package stmtc_pkg;

  // Field widths of the channels
  localparam int CMD_W  = 2;
  localparam int SLOT_W = 10;
  localparam int VAL_W  = 20;
  localparam int MAXV_W = 21;
  localparam int CNT_W  = 11;

  // Command codes of an input transaction
  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // One tree node as held in memory
  typedef struct packed {
    logic [VAL_W-1:0] vmax;
    logic [CNT_W-1:0] fcnt;
  } node_t;

endpackage

[rtl/stmtc_req_if.sv]
interface stmtc_req_if import stmtc_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SLOT_W-1:0] slot;
  logic [VAL_W-1:0]  above_count;
  logic [VAL_W-1:0]  below_count;
  logic [SLOT_W-1:0] range_low;
  logic [SLOT_W-1:0] range_high;

  modport source (
    output valid, cmd, slot, above_count, below_count, range_low, range_high,
    input  ready
  );
  modport sink (
    input  valid, cmd, slot, above_count, below_count, range_low, range_high,
    output ready
  );
endinterface

[rtl/stmtc_rsp_if.sv]
interface stmtc_rsp_if import stmtc_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic signed [MAXV_W-1:0] max_value;
  logic        [CNT_W-1:0]  flag_count;

  modport source (output valid, max_value, flag_count, input ready);
  modport sink (input valid, max_value, flag_count, output ready);
endinterface

[rtl/stmtc_cfg_if.sv]
interface stmtc_cfg_if import stmtc_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/segment_tree_max_and_threshold_count.sv]
// Segment tree over LEAVES slots giving range maximum and the number of flagged
// leaves. The tree lives in one node memory of 2*LEAVES entries with one write
// port and two read ports, each read registered. An update writes its leaf on
// the accepting cycle and then refreshes one ancestor per cycle up to the root.
// A query reads up to two nodes per tree level in one cycle, while an empty
// range skips the tree walk; the result then waits in the output register while
// the next transaction is taken. A clear, and likewise the period after reset,
// sweeps all 2*LEAVES memory entries one entry per cycle, during which no input
// transaction is accepted; threshold writes are taken at any time.
module segment_tree_max_and_threshold_count import stmtc_pkg::*; #(
  parameter int LEAVES = 1024
) (
  input logic        clk,
  input logic        rst,
  stmtc_req_if.sink  req,
  stmtc_rsp_if.source rsp,
  stmtc_cfg_if.sink  cfg
);

  localparam int AW = $clog2(2 * LEAVES);
  localparam int IW = AW + 1;
  localparam int CW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam int DEPTH = 2 * LEAVES;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UP,
    S_QRY,
    S_QWAIT
  } state_t;

  state_t state;

  logic [VAL_W-1:0]  threshold;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     cur;
  node_t             cur_node;
  logic [IW-1:0]     lidx;
  logic [IW-1:0]     ridx;
  logic              take_a;
  logic              take_b;
  logic [VAL_W-1:0]  best;
  logic [CNT_W-1:0]  cnt;
  logic signed [MAXV_W-1:0] res_max;
  logic [CNT_W-1:0]  res_cnt;

  // Node memory
  node_t mem [DEPTH];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  node_t         wr_data;
  logic          rd_a_en;
  logic [AW-1:0] rd_a_addr;
  node_t         rd_a_data;
  logic          rd_b_en;
  logic [AW-1:0] rd_b_addr;
  node_t         rd_b_data;

  // Decoded input transaction
  cmd_t             cmd;
  logic             slot_ok;
  logic [AW-1:0]    leaf;
  logic [VAL_W-1:0] leaf_val;
  node_t            leaf_node;
  logic [CW-1:0]    hi_clamp;
  logic             empty;
  logic [IW-1:0]    l_init;
  logic [IW-1:0]    r_init;
  logic             accept;

  // Walk arithmetic
  logic [AW-1:0]    parent;
  node_t            par_node;
  logic             more;
  logic [IW-1:0]    l_next;
  logic [IW-1:0]    r_next;
  logic [VAL_W-1:0] a_val;
  logic [VAL_W-1:0] b_val;
  logic [VAL_W-1:0] best_ab;
  logic [VAL_W-1:0] best_next;
  logic [CNT_W-1:0] cnt_next;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;

  // Decode the incoming transaction
  always_comb begin
    cmd       = cmd_t'(req.cmd);
    slot_ok   = CW'(req.slot) < CW'(LEAVES);
    leaf      = AW'(LEAVES) + AW'(req.slot);
    leaf_val  = (req.above_count < req.below_count) ? req.above_count : req.below_count;
    leaf_node.vmax = leaf_val;
    leaf_node.fcnt = (leaf_val >= threshold) ? CNT_W'(1) : CNT_W'(0);
    hi_clamp  = (CW'(req.range_high) >= CW'(LEAVES)) ? CW'(LEAVES - 1) : CW'(req.range_high);
    empty     = CW'(req.range_low) > hi_clamp;
    l_init    = IW'(CW'(LEAVES) + CW'(req.range_low));
    r_init    = IW'(CW'(LEAVES) + hi_clamp + CW'(1));
  end

  // Refresh one ancestor from the held child and its sibling
  always_comb begin
    parent        = cur >> 1;
    par_node.vmax = (cur_node.vmax > rd_a_data.vmax) ? cur_node.vmax : rd_a_data.vmax;
    par_node.fcnt = cur_node.fcnt + rd_a_data.fcnt;
  end

  // Fold the nodes read last cycle into the running query result
  always_comb begin
    more      = lidx < ridx;
    l_next    = (lidx + IW'(lidx[0])) >> 1;
    r_next    = ridx >> 1;
    a_val     = take_a ? rd_a_data.vmax : '0;
    b_val     = take_b ? rd_b_data.vmax : '0;
    best_ab   = (a_val > b_val) ? a_val : b_val;
    best_next = (best_ab > best) ? best_ab : best;
    cnt_next  = cnt + (take_a ? rd_a_data.fcnt : '0) + (take_b ? rd_b_data.fcnt : '0);
  end

  // Steer the memory ports
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = clr_addr;
    wr_data   = '0;
    rd_a_en   = 1'b0;
    rd_a_addr = lidx[AW-1:0];
    rd_b_en   = 1'b0;
    rd_b_addr = AW'(ridx - IW'(1));
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_IDLE: begin
        if (accept && cmd == CMD_UPDATE && slot_ok) begin
          wr_en     = 1'b1;
          wr_addr   = leaf;
          wr_data   = leaf_node;
          rd_a_en   = 1'b1;
          rd_a_addr = leaf ^ AW'(1);
        end
      end
      S_UP: begin
        wr_en     = 1'b1;
        wr_addr   = parent;
        wr_data   = par_node;
        rd_a_en   = (parent != AW'(1));
        rd_a_addr = parent ^ AW'(1);
      end
      S_QRY: begin
        rd_a_en = more;
        rd_b_en = more;
      end
      S_QWAIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_a_en) begin
      rd_a_data <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_data <= mem[rd_b_addr];
    end
  end

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg.valid && cfg.ready) begin
      threshold <= cfg.data;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // drop the result once the transaction completes, unless a new one replaces it
      if (rsp.valid && rsp.ready && state != S_QWAIT) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_UPDATE: begin
                if (slot_ok) begin
                  cur      <= leaf;
                  cur_node <= leaf_node;
                  state    <= S_UP;
                end
              end
              CMD_QUERY: begin
                lidx   <= l_init;
                ridx   <= r_init;
                take_a <= 1'b0;
                take_b <= 1'b0;
                best   <= '0;
                cnt    <= '0;
                if (empty) begin
                  res_max <= -MAXV_W'(1);
                  res_cnt <= '0;
                  state   <= S_QWAIT;
                end else begin
                  state <= S_QRY;
                end
              end
              CMD_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end
        S_UP: begin
          // advance to the parent, stop after the root
          cur      <= parent;
          cur_node <= par_node;
          if (parent == AW'(1)) begin
            state <= S_IDLE;
          end
        end
        S_QRY: begin
          best <= best_next;
          cnt  <= cnt_next;
          if (more) begin
            take_a <= lidx[0];
            take_b <= ridx[0];
            lidx   <= l_next;
            ridx   <= r_next;
          end else begin
            res_max <= $signed({1'b0, best_next});
            res_cnt <= cnt_next;
            state   <= S_QWAIT;
          end
        end
        S_QWAIT: begin
          // hold until the output register is free
          if (!rsp.valid || rsp.ready) begin
            rsp.valid      <= 1'b1;
            rsp.max_value  <= res_max;
            rsp.flag_count <= res_cnt;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
